@@ rtl/efp_pkg.sv @@
// ----------------------------------------------------------------------------
// efp_pkg
// Shared widths, register indexes, mode codes, types and saturating helpers
// for the escape-time fractal pixel engine.
// ----------------------------------------------------------------------------
package efp_pkg;

  localparam int DATA_W      = 64;
  localparam int PIX_W       = 12;
  localparam int COORD_MAX_W = 16;
  localparam int COUNT_W     = 20;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam int COORD_BITS_DEF       = 12;
  localparam int ESCAPE_RADIUS_SQ_DEF = 4;
  localparam int FRACTION_BITS_DEF    = 48;

  localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [COUNT_W-1:0] ITER_LIMIT_RST = 20'd256;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_START    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_START    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_RE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_IM   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd7;

  // fractal modes
  localparam logic [MODE_W-1:0] MODE_MANDEL  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIXED_C = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIST    = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0]  x_start;
    logic [DATA_W-1:0]  y_start;
    logic [DATA_W-1:0]  x_step;
    logic [DATA_W-1:0]  y_step;
    logic [DATA_W-1:0]  julia_re;
    logic [DATA_W-1:0]  julia_im;
    logic [COUNT_W-1:0] iteration_limit;
    logic [MODE_W-1:0]  fractal_mode;
  } cfg_t;

  // one classified point, front to back
  typedef struct packed {
    logic [DATA_W-1:0] zr;
    logic [DATA_W-1:0] zi;
    logic [DATA_W-1:0] cr;
    logic [DATA_W-1:0] ci;
    logic              deriv;
  } pt_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] res;
  } mul_rsp_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MAP,
    F_SUM,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_CHECK,
    B_SQ_RE,
    B_SQ_IM,
    B_SUM,
    B_TEST,
    B_D_RR,
    B_D_II,
    B_D_RI,
    B_D_IR,
    B_D_SUM,
    B_D_UPD,
    B_Z_P,
    B_Z_UPD,
    B_DONE
  } back_state_e;

  function automatic logic [DATA_W-1:0] sat_add(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? DATA_MIN : DATA_MAX;
    return s[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] sat_sub(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? DATA_MIN : DATA_MAX;
    return s[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] sat_dbl(logic [DATA_W-1:0] a);
    if (a[DATA_W-1] != a[DATA_W-2]) return a[DATA_W-1] ? DATA_MIN : DATA_MAX;
    return {a[DATA_W-2:0], 1'b0};
  endfunction

  // escape bound in fixed point, clipped to the largest positive word
  function automatic logic [DATA_W-1:0] esc_thr(int esc, int fb);
    logic [2*DATA_W-1:0] w;
    w = (2*DATA_W)'(esc) << fb;
    if (w > (2*DATA_W)'(DATA_MAX)) return DATA_MAX;
    return w[DATA_W-1:0];
  endfunction

endpackage

@@ rtl/efp_if.sv @@
// ----------------------------------------------------------------------------
// efp interfaces
// Valid/ready channels for pixel words, result words and register writes.
// ----------------------------------------------------------------------------
interface efp_pixel_if import efp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_col;
  logic [PIX_W-1:0] pixel_row;

  modport source (output valid, pixel_col, pixel_row, input ready);
  modport sink   (input valid, pixel_col, pixel_row, output ready);
endinterface

interface efp_result_if import efp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] iteration_count;
  logic [DATA_W-1:0]  escape_z_re;
  logic [DATA_W-1:0]  escape_z_im;
  logic [DATA_W-1:0]  escape_dz_re;
  logic [DATA_W-1:0]  escape_dz_im;

  modport source (output valid, iteration_count, escape_z_re, escape_z_im,
                  escape_dz_re, escape_dz_im, input ready);
  modport sink   (input valid, iteration_count, escape_z_re, escape_z_im,
                  escape_dz_re, escape_dz_im, output ready);
endinterface

interface efp_cfg_if import efp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/efp_mul.sv @@
// ----------------------------------------------------------------------------
// efp_mul
// Saturating signed fixed-point multiplier, built from one 32x32 unsigned
// multiplier that forms four partial products one after another.
// ----------------------------------------------------------------------------
module efp_mul import efp_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam int HALF_W = DATA_W / 2;
  localparam logic [2:0] PH_LAST_PP = 3'd3;
  localparam logic [2:0] PH_LAST_ACC = 3'd4;
  localparam logic [2:0] PH_FINAL = 3'd5;

  logic                  busy_q;
  logic                  done_q;
  logic [2:0]            phase_q;
  logic [DATA_W-1:0]     ma_q, mb_q;
  logic                  neg_q;
  logic [DATA_W-1:0]     pp_q;
  logic [1:0]            pp_sh_q;
  logic [2*DATA_W-1:0]   acc_q;
  logic [DATA_W-1:0]     res_q;

  logic                  start;
  logic [HALF_W-1:0]     a_half, b_half;
  logic [2*DATA_W-1:0]   pp_wide;
  logic [DATA_W-1:0]     rlo, lim, mag, res_d;
  logic                  hi_nz;

  assign start = req_i.start && !busy_q;

  // phase 0: lo*lo, 1: lo*hi, 2: hi*lo, 3: hi*hi
  assign a_half = phase_q[1] ? ma_q[DATA_W-1:HALF_W] : ma_q[HALF_W-1:0];
  assign b_half = phase_q[0] ? mb_q[DATA_W-1:HALF_W] : mb_q[HALF_W-1:0];

  always_comb begin
    unique case (pp_sh_q)
      2'd0:    pp_wide = {{DATA_W{1'b0}}, pp_q};
      2'd1:    pp_wide = {{HALF_W{1'b0}}, pp_q, {HALF_W{1'b0}}};
      default: pp_wide = {pp_q, {DATA_W{1'b0}}};
    endcase
  end

  always_comb begin
    rlo   = acc_q[FRACTION_BITS +: DATA_W];
    hi_nz = |acc_q[2*DATA_W-1:FRACTION_BITS+DATA_W];
    lim   = neg_q ? DATA_MIN : DATA_MAX;
    mag   = (hi_nz || rlo > lim) ? lim : rlo;
    res_d = neg_q ? (DATA_W'(0) - mag) : mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        busy_q  <= 1'b1;
        phase_q <= '0;
      end else if (busy_q) begin
        phase_q <= phase_q + 3'd1;
        if (phase_q == PH_FINAL) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      ma_q  <= req_i.a[DATA_W-1] ? (DATA_W'(0) - req_i.a) : req_i.a;
      mb_q  <= req_i.b[DATA_W-1] ? (DATA_W'(0) - req_i.b) : req_i.b;
      neg_q <= req_i.a[DATA_W-1] ^ req_i.b[DATA_W-1];
      acc_q <= '0;
    end else if (busy_q) begin
      if (phase_q <= PH_LAST_PP) begin
        pp_q    <= a_half * b_half;
        pp_sh_q <= 2'(phase_q[1]) + 2'(phase_q[0]);
      end
      if (phase_q != 3'd0 && phase_q <= PH_LAST_ACC) begin
        acc_q <= acc_q + pp_wide;
      end
      if (phase_q == PH_FINAL) begin
        res_q <= res_d;
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

@@ rtl/efp_front.sv @@
// ----------------------------------------------------------------------------
// efp_front
// Accepts pixel words, maps column and row to a point with a bit-serial
// multiply by the step registers, picks c by mode and queues the point.
// ----------------------------------------------------------------------------
module efp_front import efp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  efp_pixel_if.sink pix_i,
  input  cfg_t  cfg_i,
  output pt_t   ent_o,
  output logic  push_o,
  input  logic  full_i
);

  localparam int AW = DATA_W + COORD_BITS + 1;
  localparam int CW = $clog2(COORD_BITS + 1);

  front_state_e state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [COORD_BITS-1:0] col_q, row_q;
  logic [AW-1:0]         acc_x_q, acc_y_q;
  pt_t                   ent_q;

  logic                  accept;
  logic [AW-1:0]         step_x_ext, step_y_ext;
  logic [DATA_W-1:0]     px_d, py_d;
  logic                  julia;

  function automatic logic [DATA_W-1:0] fit64(logic [AW-1:0] v);
    logic [AW-DATA_W:0] upper;
    upper = v[AW-1:DATA_W-1];
    if (&upper || ~|upper) return v[DATA_W-1:0];
    return v[AW-1] ? DATA_MIN : DATA_MAX;
  endfunction

  assign accept     = pix_i.valid && pix_i.ready;
  assign step_x_ext = {{(COORD_BITS+1){cfg_i.x_step[DATA_W-1]}}, cfg_i.x_step};
  assign step_y_ext = {{(COORD_BITS+1){cfg_i.y_step[DATA_W-1]}}, cfg_i.y_step};
  assign julia      = cfg_i.fractal_mode == MODE_FIXED_C;

  always_comb begin
    px_d = sat_add(fit64(acc_x_q), cfg_i.x_start);
    py_d = sat_add(fit64(acc_y_q), cfg_i.y_start);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      F_IDLE: begin
        if (pix_i.valid) begin
          state_d = F_MAP;
          cnt_d   = CW'(COORD_BITS);
        end
      end
      F_MAP: begin
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) state_d = F_SUM;
      end
      F_SUM: state_d = F_PUSH;
      F_PUSH: begin
        if (!full_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    pix_i.ready = state_q == F_IDLE;
    push_o      = (state_q == F_PUSH) && !full_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // msb-first shift and add, index times step is exact until the final clip
  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q   <= COORD_BITS'(COORD_MAX_W'(pix_i.pixel_col));
      row_q   <= COORD_BITS'(COORD_MAX_W'(pix_i.pixel_row));
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else if (state_q == F_MAP) begin
      acc_x_q <= (acc_x_q << 1) + (col_q[COORD_BITS-1] ? step_x_ext : '0);
      acc_y_q <= (acc_y_q << 1) + (row_q[COORD_BITS-1] ? step_y_ext : '0);
      col_q   <= col_q << 1;
      row_q   <= row_q << 1;
    end else if (state_q == F_SUM) begin
      ent_q.zr    <= px_d;
      ent_q.zi    <= py_d;
      ent_q.cr    <= julia ? cfg_i.julia_re : px_d;
      ent_q.ci    <= julia ? cfg_i.julia_im : py_d;
      ent_q.deriv <= cfg_i.fractal_mode == MODE_DIST;
    end
  end

  assign ent_o = ent_q;

endmodule

@@ rtl/efp_queue.sv @@
// ----------------------------------------------------------------------------
// efp_queue
// Small register FIFO between the mapping front and the iteration back.
// ----------------------------------------------------------------------------
module efp_queue import efp_pkg::*; #(
  parameter int WIDTH = $bits(pt_t),
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]    fill_q;

  assign full_o  = fill_q == NW'(DEPTH);
  assign empty_o = fill_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      if (push_i && !pop_i)      fill_q <= fill_q + NW'(1);
      else if (pop_i && !push_i) fill_q <= fill_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");

endmodule

@@ rtl/efp_back.sv @@
// ----------------------------------------------------------------------------
// efp_back
// Escape-time iteration engine: takes queued points, runs z = z*z + c (and
// the derivative in distance mode) on a shared multiplier, registers result.
// ----------------------------------------------------------------------------
module efp_back import efp_pkg::*; #(
  parameter int ESCAPE_RADIUS_SQ = ESCAPE_RADIUS_SQ_DEF,
  parameter int FRACTION_BITS    = FRACTION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [COUNT_W-1:0] limit_i,
  input  pt_t                ent_i,
  input  logic               empty_i,
  output logic               pop_o,
  efp_result_if.source       res_o
);

  localparam logic [DATA_W-1:0] THR = esc_thr(ESCAPE_RADIUS_SQ, FRACTION_BITS);
  localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRACTION_BITS;

  back_state_e state_q, state_d;
  logic        issued_q;
  logic        out_valid_q;

  logic [DATA_W-1:0]  zr_q, zi_q, cr_q, ci_q, dr_q, di_q;
  logic               dist_q, escaped_q;
  logic [COUNT_W-1:0] count_q;
  logic [DATA_W-1:0]  sq_re_q, sq_im_q, mag_q, diff_q;
  logic [DATA_W-1:0]  t_a_q, t_b_q, t_c_q, t_d_q, nd_re_q, nd_im_q;
  logic [COUNT_W-1:0] out_count_q;
  logic [DATA_W-1:0]  out_zr_q, out_zi_q, out_dr_q, out_di_q;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  logic     mul_state;
  logic     out_load;

  efp_mul #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (!empty_i) state_d = B_CHECK;
      B_CHECK: state_d = (count_q == limit_i) ? B_DONE : B_SQ_RE;
      B_SQ_RE: if (mul_rsp.done) state_d = B_SQ_IM;
      B_SQ_IM: if (mul_rsp.done) state_d = B_SUM;
      B_SUM:   state_d = B_TEST;
      B_TEST: begin
        if ($signed(mag_q) < $signed(THR)) state_d = dist_q ? B_D_RR : B_Z_P;
        else state_d = B_DONE;
      end
      B_D_RR:  if (mul_rsp.done) state_d = B_D_II;
      B_D_II:  if (mul_rsp.done) state_d = B_D_RI;
      B_D_RI:  if (mul_rsp.done) state_d = B_D_IR;
      B_D_IR:  if (mul_rsp.done) state_d = B_D_SUM;
      B_D_SUM: state_d = B_D_UPD;
      B_D_UPD: state_d = B_Z_P;
      B_Z_P:   if (mul_rsp.done) state_d = B_Z_UPD;
      B_Z_UPD: state_d = B_CHECK;
      B_DONE:  if (!out_valid_q || res_o.ready) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    mul_state = 1'b0;
    mul_req.a = zr_q;
    mul_req.b = zr_q;
    unique case (state_q)
      B_SQ_RE: begin mul_state = 1'b1; mul_req.a = zr_q; mul_req.b = zr_q; end
      B_SQ_IM: begin mul_state = 1'b1; mul_req.a = zi_q; mul_req.b = zi_q; end
      B_D_RR:  begin mul_state = 1'b1; mul_req.a = zr_q; mul_req.b = dr_q; end
      B_D_II:  begin mul_state = 1'b1; mul_req.a = zi_q; mul_req.b = di_q; end
      B_D_RI:  begin mul_state = 1'b1; mul_req.a = zr_q; mul_req.b = di_q; end
      B_D_IR:  begin mul_state = 1'b1; mul_req.a = zi_q; mul_req.b = dr_q; end
      B_Z_P:   begin mul_state = 1'b1; mul_req.a = zr_q; mul_req.b = zi_q; end
      default: mul_state = 1'b0;
    endcase
    mul_req.start = mul_state && !issued_q;
    pop_o         = (state_q == B_IDLE) && !empty_i;
    out_load      = (state_q == B_DONE) && (!out_valid_q || res_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul_req.start)     issued_q <= 1'b1;
      else if (mul_rsp.done) issued_q <= 1'b0;
      if (out_load)          out_valid_q <= 1'b1;
      else if (res_o.ready)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          zr_q      <= ent_i.zr;
          zi_q      <= ent_i.zi;
          cr_q      <= ent_i.cr;
          ci_q      <= ent_i.ci;
          dist_q    <= ent_i.deriv;
          dr_q      <= ONE;
          di_q      <= '0;
          count_q   <= '0;
          escaped_q <= 1'b0;
        end
      end
      B_SQ_RE: if (mul_rsp.done) sq_re_q <= mul_rsp.res;
      B_SQ_IM: if (mul_rsp.done) sq_im_q <= mul_rsp.res;
      B_SUM: begin
        mag_q  <= sat_add(sq_re_q, sq_im_q);
        diff_q <= sat_sub(sq_re_q, sq_im_q);
      end
      B_TEST: begin
        if ($signed(mag_q) < $signed(THR)) count_q <= count_q + COUNT_W'(1);
        else escaped_q <= 1'b1;
      end
      B_D_RR: if (mul_rsp.done) t_a_q <= mul_rsp.res;
      B_D_II: if (mul_rsp.done) t_b_q <= mul_rsp.res;
      B_D_RI: if (mul_rsp.done) t_c_q <= mul_rsp.res;
      B_D_IR: if (mul_rsp.done) t_d_q <= mul_rsp.res;
      B_D_SUM: begin
        nd_re_q <= sat_sub(t_a_q, t_b_q);
        nd_im_q <= sat_add(t_c_q, t_d_q);
      end
      B_D_UPD: begin
        dr_q <= sat_add(sat_dbl(nd_re_q), ONE);
        di_q <= sat_dbl(nd_im_q);
      end
      // zr*zi cross product reuses the first derivative temporary
      B_Z_P: if (mul_rsp.done) t_a_q <= mul_rsp.res;
      B_Z_UPD: begin
        zr_q <= sat_add(diff_q, cr_q);
        zi_q <= sat_add(sat_dbl(t_a_q), ci_q);
      end
      default: ;
    endcase
    if (out_load) begin
      out_count_q <= count_q;
      out_zr_q    <= escaped_q ? zr_q : '0;
      out_zi_q    <= escaped_q ? zi_q : '0;
      out_dr_q    <= (escaped_q && dist_q) ? dr_q : '0;
      out_di_q    <= (escaped_q && dist_q) ? di_q : '0;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.iteration_count = out_count_q;
  assign res_o.escape_z_re     = out_zr_q;
  assign res_o.escape_z_im     = out_zi_q;
  assign res_o.escape_dz_re    = out_dr_q;
  assign res_o.escape_dz_im    = out_di_q;

  a_mul_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_rsp.busy) else $error("multiplier started while busy");

  a_done_matches_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> issued_q) else $error("multiplier done without request");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == B_DONE)
    else $error("result word appeared outside done state");

endmodule

@@ rtl/escape_time_fractal_pixel.sv @@
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel
// Mandelbrot / Julia escape-time engine in signed fixed point with
// FRACTION_BITS fraction bits. Each pixel word is mapped to a point by a
// bit-serial front, then waits in a two-entry queue for the iteration back
// end, which holds one pixel at a time. All products go through one shared
// 32x32 multiplier that needs four partial products per 64-bit product. The
// front takes the next pixel while the back iterates, and the back finishes
// into an output register, so a stalled result word holds the back only
// when the next pixel is done. Register writes are always accepted and must
// only be made while the block is idle.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel import efp_pkg::*; #(
  parameter int COORD_BITS       = COORD_BITS_DEF,
  parameter int ESCAPE_RADIUS_SQ = ESCAPE_RADIUS_SQ_DEF,
  parameter int FRACTION_BITS    = FRACTION_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  efp_pixel_if.sink     pix_i,
  efp_cfg_if.sink       cfg_i,
  efp_result_if.source  res_o
);

  cfg_t cfg_q;
  pt_t  front_ent, back_ent;
  logic push, full, pop, empty;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_start         <= '0;
      cfg_q.y_start         <= '0;
      cfg_q.x_step          <= '0;
      cfg_q.y_step          <= '0;
      cfg_q.julia_re        <= '0;
      cfg_q.julia_im        <= '0;
      cfg_q.iteration_limit <= ITER_LIMIT_RST;
      cfg_q.fractal_mode    <= MODE_MANDEL;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_X_START:    cfg_q.x_start         <= cfg_i.data;
        CFG_Y_START:    cfg_q.y_start         <= cfg_i.data;
        CFG_X_STEP:     cfg_q.x_step          <= cfg_i.data;
        CFG_Y_STEP:     cfg_q.y_step          <= cfg_i.data;
        CFG_JULIA_RE:   cfg_q.julia_re        <= cfg_i.data;
        CFG_JULIA_IM:   cfg_q.julia_im        <= cfg_i.data;
        CFG_ITER_LIMIT: cfg_q.iteration_limit <= cfg_i.data[COUNT_W-1:0];
        CFG_MODE:       cfg_q.fractal_mode    <= cfg_i.data[MODE_W-1:0];
      endcase
    end
  end

  efp_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix_i),
    .cfg_i (cfg_q),
    .ent_o (front_ent),
    .push_o(push),
    .full_i(full)
  );

  efp_queue #(
    .WIDTH($bits(pt_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_ent),
    .full_o (full),
    .pop_i  (pop),
    .data_o (back_ent),
    .empty_o(empty)
  );

  efp_back #(
    .ESCAPE_RADIUS_SQ(ESCAPE_RADIUS_SQ),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .limit_i(cfg_q.iteration_limit),
    .ent_i  (back_ent),
    .empty_i(empty),
    .pop_o  (pop),
    .res_o  (res_o)
  );

endmodule
